/* hw/rtl/point_in_polygon_test_core_macros.svh */
// Assertion macros for the point-in-polygon test core.
// Used by modules that carry concurrent checks; expects ports named clock and reset.
`ifndef POINT_IN_POLYGON_TEST_CORE_MACROS_SVH
`define POINT_IN_POLYGON_TEST_CORE_MACROS_SVH

// same-cycle implication
`define PIP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PIP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/pip_pkg.sv */
// Shared types and constants for the point-in-polygon test core.
// No dependencies; imported by the controller, datapath and top level.
package pip_pkg;

   localparam int MAX_VERTICES      = 16;
   localparam int IDX_W             = $clog2(MAX_VERTICES);
   localparam int CNT_W             = $clog2(MAX_VERTICES + 1);
   localparam int MIN_POLY_VERTICES = 3;
   localparam int COORD_W           = 24;
   localparam int DIFF_W            = COORD_W + 1;
   localparam int PROD_W            = 2 * DIFF_W;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   typedef struct packed {
      logic [1:0]                 cmd;
      logic signed [COORD_W-1:0]  coord_x;
      logic signed [COORD_W-1:0]  coord_y;
   } req_type;

   typedef struct packed {
      logic inside_res;
      logic status;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic             clear;
      logic             append;
      logic             load_pt;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             rd_first;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             pipe_busy;
      logic             parity;
   } sts_type;

endpackage

/* hw/rtl/pip_datapath.sv */
// Datapath: vertex store, count, edge-test pipeline and even-odd flag.
// Depends on pip_pkg; driven by pip_controller through ctl_type.
module pip_datapath (
   input  logic              clock,
   input  logic              reset,
   input  pip_pkg::req_type  req_data,
   input  pip_pkg::ctl_type  ctl,
   output pip_pkg::sts_type  sts
);
   import pip_pkg::*;

   logic signed [COORD_W-1:0] x_mem [MAX_VERTICES];
   logic signed [COORD_W-1:0] y_mem [MAX_VERTICES];

   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [COORD_W-1:0] px_ff, py_ff;

   // stage 1: read data plus previous vertex
   logic                      rd_vld_ff, rd_first_ff;
   logic signed [COORD_W-1:0] xi_ff, yi_ff, xj_ff, yj_ff;

   // stage 2: registered products
   logic                      e_vld_ff, e_straddle_ff, e_dyneg_ff;
   logic signed [PROD_W-1:0]  lhs_ff, rhs_ff;

   logic                      inside_ff, inside_in;

   logic signed [DIFF_W-1:0]  dy, dx, ax, ay;
   logic                      straddle, left;

   // vertex store
   always_ff @(posedge clock) begin
      if (ctl.append) begin
         x_mem[count_ff[IDX_W-1:0]] <= req_data.coord_x;
         y_mem[count_ff[IDX_W-1:0]] <= req_data.coord_y;
      end
      if (ctl.rd_en) begin
         xi_ff <= x_mem[ctl.rd_addr];
         yi_ff <= y_mem[ctl.rd_addr];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.append) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // edge (i, j): i is the fresh read, j the one before it
   always_comb begin
      dy       = DIFF_W'(yj_ff) - DIFF_W'(yi_ff);
      dx       = DIFF_W'(xj_ff) - DIFF_W'(xi_ff);
      ax       = DIFF_W'(px_ff) - DIFF_W'(xi_ff);
      ay       = DIFF_W'(py_ff) - DIFF_W'(yi_ff);
      straddle = (yi_ff > py_ff) != (yj_ff > py_ff);
      left     = e_dyneg_ff ? (lhs_ff > rhs_ff) : (lhs_ff < rhs_ff);
      inside_in = inside_ff;
      if (ctl.load_pt) begin
         inside_in = 1'b0;
      end else if (e_vld_ff && e_straddle_ff && left) begin
         inside_in = !inside_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_pt) begin
         px_ff <= req_data.coord_x;
         py_ff <= req_data.coord_y;
      end
      if (rd_vld_ff) begin
         xj_ff <= xi_ff;
         yj_ff <= yi_ff;
      end
      lhs_ff        <= ax * dy;
      rhs_ff        <= dx * ay;
      e_straddle_ff <= straddle;
      e_dyneg_ff    <= dy[DIFF_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         rd_vld_ff   <= 1'b0;
         rd_first_ff <= 1'b0;
         e_vld_ff    <= 1'b0;
         inside_ff   <= 1'b0;
      end else begin
         count_ff    <= count_in;
         rd_vld_ff   <= ctl.rd_en;
         rd_first_ff <= ctl.rd_first;
         e_vld_ff    <= rd_vld_ff && !rd_first_ff;
         inside_ff   <= inside_in;
      end
   end

   assign sts.count     = count_ff;
   assign sts.pipe_busy = rd_vld_ff || e_vld_ff;
   assign sts.parity    = inside_ff;

endmodule

/* hw/rtl/pip_controller.sv */
// Controller: command decode, edge walk sequencer and response register.
// Depends on pip_pkg and point_in_polygon_test_core_macros.svh.
`include "point_in_polygon_test_core_macros.svh"

module pip_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pip_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pip_pkg::rsp_type  rsp_data,
   output pip_pkg::ctl_type  ctl,
   input  pip_pkg::sts_type  sts
);
   import pip_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] walk_ff, walk_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             slot_free, req_fire, full, poly_ok;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire  = req_valid && req_ready;
   assign full      = sts.count == CNT_W'(MAX_VERTICES);
   assign poly_ok   = sts.count >= CNT_W'(MIN_POLY_VERTICES);

   always_comb begin
      state_in     = state_ff;
      walk_in      = walk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ctl          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_data_in = '0;
               case (req_data.cmd)
                  CMD_CLEAR: begin
                     ctl.clear    = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_APPEND: begin
                     ctl.append         = !full;
                     rsp_data_in.status = full;
                     rsp_valid_in       = 1'b1;
                  end
                  CMD_QUERY: begin
                     ctl.load_pt = 1'b1;
                     if (poly_ok) begin
                        walk_in  = '0;
                        state_in = ST_WALK;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            // first read fetches the last vertex as the j of edge 0
            ctl.rd_en    = 1'b1;
            ctl.rd_first = walk_ff == '0;
            if (walk_ff == '0) begin
               ctl.rd_addr = IDX_W'(sts.count - CNT_W'(1));
            end else begin
               ctl.rd_addr = IDX_W'(walk_ff - CNT_W'(1));
            end
            walk_in = walk_ff + CNT_W'(1);
            if (walk_ff == sts.count) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy && slot_free) begin
               rsp_data_in.inside_res = sts.parity;
               rsp_data_in.status     = 1'b0;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PIP_ASSERT_NEXT(a_query_walks, req_fire && req_data.cmd == CMD_QUERY && poly_ok, state_ff == ST_WALK, "query on a polygon did not start a walk")
   `PIP_ASSERT_SAME(a_walk_bound, state_ff == ST_WALK, walk_ff <= sts.count, "walk index ran past vertex count")
   `PIP_ASSERT_NEXT(a_full_status, req_fire && req_data.cmd == CMD_APPEND && full, rsp_valid_ff && rsp_data_ff.status, "append to full store not reported")
   `PIP_ASSERT_SAME(a_count_bound, 1'b1, sts.count <= CNT_W'(MAX_VERTICES), "vertex count above capacity")

endmodule

/* hw/rtl/point_in_polygon_test_core.sv */
// Point-in-polygon test core, even-odd ray casting in exact fixed point.
//
// Usage: one valid/ready request channel (req_*) carries a command with X/Y
// coordinates: clear polygon, append vertex, or query point. Every request
// transaction yields exactly one response transaction on rsp_* holding
// inside_res and status (status set when an append hit a full store).
// Clear and append answer one cycle after acceptance. A query on a polygon
// of n >= 3 vertices reads the vertex store once per cycle (n+1 reads, the
// last vertex first to close the polygon), then drains a three-stage edge
// test pipeline; the reads are paced by the single read port of the vertex
// store. Queries on fewer than three vertices answer at once with outside.
// One request is in flight at a time; the next request is taken as soon as
// the previous one has a response registered, provided that register is
// empty or being drained in the same cycle. A stalled rsp_ready holds the
// response and blocks new requests. Synchronous reset empties the polygon
// and drops any pending response; vertex contents are not cleared.
// Depends on pip_pkg, pip_controller and pip_datapath.
module point_in_polygon_test_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pip_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pip_pkg::rsp_type  rsp_data
);
   import pip_pkg::*;

   ctl_type ctl;
   sts_type sts;

   pip_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .ctl       (ctl),
      .sts       (sts)
   );

   pip_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .ctl      (ctl),
      .sts      (sts)
   );

endmodule

/* tb/point_in_polygon_test_core_tb.sv */
// Self-checking testbench for point_in_polygon_test_core: clear/append/query traffic
// with random idling on both channels, each response checked against an in-bench predictor.
// Depends on pip_pkg and the point_in_polygon_test_core RTL.
module point_in_polygon_test_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pip_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int COORD_MAX = 8388607;
   localparam int COORD_MIN = -8388608;
   localparam int TAIL_CYCLES = 40;
   localparam int HOLD_CYCLES = 400;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type pending_req[$];
   rsp_type expected_rsp[$];

   // predictor copy of the polygon
   int poly_x[MAX_VERTICES];
   int poly_y[MAX_VERTICES];
   int poly_count = 0;

   int idle_pct = 21;
   logic hold_rsp = 1'b0;
   int accepted_cnt = 0;
   int error_cnt = 0;
   int queued_cnt = 0;

   point_in_polygon_test_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_cnt++;
   endtask

   // even-odd crossing count, exact 64-bit cross-multiplied compare
   function automatic logic ray_parity(int px, int py);
      longint xi, yi, xj, yj, dy, lhs, rhs;
      logic odd;
      logic left;
      int j;
      odd = 1'b0;
      if (poly_count < MIN_POLY_VERTICES) return 1'b0;
      j = poly_count - 1;
      for (int i = 0; i < poly_count; i++) begin
         xi = poly_x[i];
         yi = poly_y[i];
         xj = poly_x[j];
         yj = poly_y[j];
         if ((yi > py) != (yj > py)) begin
            dy  = yj - yi;
            lhs = (longint'(px) - xi) * dy;
            rhs = (xj - xi) * (longint'(py) - yi);
            left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
            if (left) odd = ~odd;
         end
         j = i;
      end
      return odd;
   endfunction

   function automatic rsp_type predict_response(req_type r);
      rsp_type res;
      res = '0;
      case (r.cmd)
         CMD_CLEAR: begin
            poly_count = 0;
         end
         CMD_APPEND: begin
            if (poly_count < MAX_VERTICES) begin
               poly_x[poly_count] = int'(r.coord_x);
               poly_y[poly_count] = int'(r.coord_y);
               poly_count++;
            end else begin
               res.status = 1'b1;
            end
         end
         CMD_QUERY: begin
            res.inside_res = ray_parity(int'(r.coord_x), int'(r.coord_y));
         end
         default: ;
      endcase
      return res;
   endfunction

   // driver: offers pending transactions, predicts on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsp.push_back(predict_response(req_data));
            accepted_cnt++;
         end
         if (!req_valid || req_ready) begin
            if (pending_req.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_req.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random backpressure, compares each response transaction
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("response with nothing expected");
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.inside_res !== want.inside_res)
                  report_mismatch($sformatf("inside_res got %b want %b",
                                            rsp_data.inside_res, want.inside_res));
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status got %b want %b",
                                            rsp_data.status, want.status));
            end
         end
         rsp_ready <= !hold_rsp && ($urandom_range(99) >= idle_pct);
      end
   end

   task automatic queue_req(logic [1:0] c, int x, int y);
      req_type r;
      r.cmd     = c;
      r.coord_x = x[COORD_W-1:0];
      r.coord_y = y[COORD_W-1:0];
      pending_req.push_back(r);
      if (c != CMD_UNUSED) queued_cnt++;
   endtask

   function automatic int wide_coord();
      logic signed [COORD_W-1:0] v;
      v = COORD_W'($urandom);
      return int'(v);
   endfunction

   function automatic int span_coord(int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   // one session: mostly a clear, some appends (may be too few or too many), then queries
   task automatic queue_session();
      int span, nv, nq, pick, k;
      int vx[20];
      int vy[20];
      case ($urandom_range(3))
         0: span = 8;
         1: span = 1000;
         2: span = 1 << 20;
         default: span = COORD_MAX;
      endcase
      pick = $urandom_range(99);
      if (pick < 10) nv = $urandom_range(2);
      else if (pick < 85) nv = $urandom_range(MAX_VERTICES, MIN_POLY_VERTICES);
      else nv = $urandom_range(MAX_VERTICES + 3, MAX_VERTICES + 1);
      if ($urandom_range(99) < 90) queue_req(CMD_CLEAR, wide_coord(), wide_coord());
      for (int v = 0; v < nv; v++) begin
         if ($urandom_range(99) < 5) begin
            vx[v] = wide_coord();
            vy[v] = wide_coord();
         end else begin
            vx[v] = span_coord(span);
            vy[v] = span_coord(span);
         end
         queue_req(CMD_APPEND, vx[v], vy[v]);
      end
      nq = $urandom_range(6, 1);
      for (int q = 0; q < nq; q++) begin
         pick = $urandom_range(99);
         k = (nv > 0) ? $urandom_range(nv - 1) : 0;
         if (pick < 60 || nv == 0)
            queue_req(CMD_QUERY, span_coord(span), span_coord(span));
         else if (pick < 80)
            queue_req(CMD_QUERY, span_coord(span), vy[k]);   // on a vertex row
         else if (pick < 90)
            queue_req(CMD_QUERY, vx[k], vy[k]);
         else
            queue_req(CMD_QUERY, wide_coord(), wide_coord());
      end
      if ($urandom_range(99) < 5) queue_req(CMD_UNUSED, wide_coord(), wide_coord());
   endtask

   task automatic wait_drained();
      wait (pending_req.size() == 0 && !req_valid && expected_rsp.size() == 0);
      @(negedge clock);
   endtask

   task automatic run_random(int count);
      int goal;
      goal = queued_cnt + count;
      while (queued_cnt < goal) queue_session();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      wait (!reset);
      @(negedge clock);
      // directed: empty polygon, unused command, degenerate and full-range square
      queue_req(CMD_QUERY, 0, 0);
      queue_req(CMD_UNUSED, COORD_MAX, COORD_MIN);
      queue_req(CMD_CLEAR, COORD_MIN, COORD_MAX);
      queue_req(CMD_APPEND, COORD_MIN, COORD_MIN);
      queue_req(CMD_APPEND, COORD_MAX, COORD_MIN);
      queue_req(CMD_QUERY, 0, COORD_MIN + 1);
      queue_req(CMD_APPEND, COORD_MAX, COORD_MAX);
      queue_req(CMD_APPEND, COORD_MIN, COORD_MAX);
      queue_req(CMD_QUERY, 0, 0);
      queue_req(CMD_QUERY, COORD_MIN, 0);
      queue_req(CMD_QUERY, COORD_MAX, COORD_MAX);
      queue_req(CMD_QUERY, 0, COORD_MIN);
      queue_req(CMD_QUERY, -1, -1);
      queue_req(CMD_CLEAR, 0, 0);
      queue_req(CMD_QUERY, 0, 0);
      wait_drained();

      run_random(800);
      wait_drained();          // sender stays quiet until all responses are back
      idle_pct = 0;
      run_random(500);
      wait_drained();
      idle_pct = 21;
      run_random(700);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_rsp.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_rsp.size()));
      if (error_cnt == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // long receiver hold-off so the core backs up and stalls its input
   initial begin
      wait (accepted_cnt >= 300);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #5ms;
      $display("TIMEOUT @%0t", $time);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
